// ----- hw/rtl/bmp24_stream_decoder_assert.svh -----
// Assertion macros shared by the BMP decoder RTL files.
// Depends on nothing; included by the modules that carry assertions.
`ifndef BMP24_STREAM_DECODER_ASSERT_SVH
`define BMP24_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BMP24_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BMP24_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/bmp24_pkg.sv -----
// Types and constants for the 24-bit BMP stream decoder.
// Used by bmp24_parser and bmp24_stream_decoder; depends on nothing.
package bmp24_pkg;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PIXEL  = 2'd1,
        PH_PAD    = 2'd2,
        PH_IDLE   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PIXEL   = 2'd0,
        KIND_BAD_SIG = 2'd1,
        KIND_NOT_24  = 2'd2,
        KIND_SIZE    = 2'd3
    } t_kind;

    localparam logic [7:0]  SIG_B       = 8'h42;
    localparam logic [7:0]  SIG_M       = 8'h4D;
    localparam logic [15:0] DEPTH_BPP   = 16'd24;
    localparam logic [5:0]  IDX_FIRST   = 6'd0;
    localparam logic [5:0]  IDX_SIG     = 6'd1;
    localparam logic [5:0]  IDX_WIDTH   = 6'd21;
    localparam logic [5:0]  IDX_HEIGHT  = 6'd25;
    localparam logic [5:0]  IDX_DEPTH   = 6'd29;
    localparam logic [5:0]  IDX_HDR_END = 6'd53;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] column;
        logic [11:0] row;
        logic        last_pixel;
        logic [12:0] image_width;
        logic [12:0] image_height;
    } t_result;

endpackage

// ----- hw/rtl/bmp24_stream_decoder.sv -----
// Top level of the 24-bit BMP stream decoder: parser plus result register.
// Depends on bmp24_pkg, bmp24_parser and the assertion macros header.
`include "bmp24_stream_decoder_assert.svh"

// The decoder takes one file byte per clock and gives at most one word per byte:
// a pixel on every third pixel byte, or an error code in the header. A result
// appears on the output in the cycle after the byte that causes it is accepted. The
// result register decouples the two sides, so o_in_ready drops only while that
// register holds a word the sink has not taken; with the sink ready the rate is
// one byte per cycle, set by the single parser step between input and result
// register. Raising i_file_start with a byte restarts the decoder at header byte 0.
module bmp24_stream_decoder #(
    parameter int MAX_DIM = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_file_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [11:0] o_column,
    output logic [11:0] o_row,
    output logic        o_last_pixel,
    output logic [12:0] o_image_width,
    output logic [12:0] o_image_height
);

    logic               step;
    logic               res_valid;
    bmp24_pkg::t_result res;
    logic               r_out_valid;
    bmp24_pkg::t_result r_res;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign step       = i_in_valid && o_in_ready;

    bmp24_parser #(
        .MAX_DIM (MAX_DIM)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_data_byte  (i_data_byte),
        .i_file_start (i_file_start),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_res <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_res.kind;
    assign o_red          = r_res.red;
    assign o_green        = r_res.green;
    assign o_blue         = r_res.blue;
    assign o_column       = r_res.column;
    assign o_row          = r_res.row;
    assign o_last_pixel   = r_res.last_pixel;
    assign o_image_width  = r_res.image_width;
    assign o_image_height = r_res.image_height;

    `BMP24_ASSERT_NOW(a_error_fields_zero, i_clk, i_rst_n, o_out_valid && o_kind != bmp24_pkg::KIND_PIXEL, o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0 && o_column == 12'd0 && o_row == 12'd0 && !o_last_pixel && o_image_width == 13'd0 && o_image_height == 13'd0, "error word carries pixel data")
    `BMP24_ASSERT_NOW(a_last_is_pixel, i_clk, i_rst_n, o_out_valid && o_last_pixel, o_kind == bmp24_pkg::KIND_PIXEL, "last flag on a non-pixel word")
    `BMP24_ASSERT_NEXT(a_stall_no_loss, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "pending word dropped while stalled")

endmodule

// ----- hw/rtl/bmp24_parser.sv -----
// Header parser and pixel assembler of the BMP decoder: one byte per step.
// Depends on bmp24_pkg and the assertion macros header.
`include "bmp24_stream_decoder_assert.svh"

module bmp24_parser #(
    parameter int MAX_DIM = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_data_byte,
    input  logic               i_file_start,
    output logic               o_res_valid,
    output bmp24_pkg::t_result o_res
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    bmp24_pkg::t_phase r_phase, n_phase;
    logic [5:0]        r_hcnt, n_hcnt;
    logic [7:0]        r_first, n_first;
    logic [31:0]       r_field, n_field;
    logic [DIM_W-1:0]  r_width, n_width;
    logic [DIM_W-1:0]  r_height, n_height;
    logic [DIM_W-1:0]  r_col, n_col;
    logic [DIM_W-1:0]  r_row, n_row;
    logic [1:0]        r_bip, n_bip;
    logic [7:0]        r_blue, n_blue;
    logic [7:0]        r_green, n_green;
    logic [1:0]        r_pad, n_pad;

    bmp24_pkg::t_phase phase_c;
    logic [5:0]        hcnt_c;
    logic [DIM_W-1:0]  col_inc;
    logic [DIM_W-1:0]  row_inc;
    logic [1:0]        pad_row;

    always_comb begin
        // A start-of-file byte restarts the parse with this byte as header byte 0.
        phase_c = i_file_start ? bmp24_pkg::PH_HEADER : r_phase;
        hcnt_c  = i_file_start ? 6'd0 : r_hcnt;
        col_inc = r_col + DIM_W'(1);
        row_inc = r_row + DIM_W'(1);
        // Row padding to a 4-byte multiple for 3-byte pixels equals width mod 4.
        pad_row = 2'(r_width);

        n_phase  = phase_c;
        n_hcnt   = hcnt_c;
        n_first  = r_first;
        n_field  = r_field;
        n_width  = r_width;
        n_height = r_height;
        n_col    = r_col;
        n_row    = r_row;
        n_bip    = r_bip;
        n_blue   = r_blue;
        n_green  = r_green;
        n_pad    = r_pad;

        o_res_valid = 1'b0;
        o_res       = '0;

        case (phase_c)
            bmp24_pkg::PH_HEADER: begin
                n_hcnt  = hcnt_c + 6'd1;
                n_field = {i_data_byte, r_field[31:8]};
                if (hcnt_c == bmp24_pkg::IDX_FIRST) begin
                    n_first = i_data_byte;
                end else if (hcnt_c == bmp24_pkg::IDX_SIG) begin
                    if (r_first != bmp24_pkg::SIG_B || i_data_byte != bmp24_pkg::SIG_M) begin
                        o_res_valid = 1'b1;
                        o_res.kind  = bmp24_pkg::KIND_BAD_SIG;
                        n_phase     = bmp24_pkg::PH_IDLE;
                    end
                end else if (hcnt_c == bmp24_pkg::IDX_WIDTH) begin
                    if (n_field > 32'(MAX_DIM)) begin
                        o_res_valid = 1'b1;
                        o_res.kind  = bmp24_pkg::KIND_SIZE;
                        n_phase     = bmp24_pkg::PH_IDLE;
                    end else begin
                        n_width = DIM_W'(n_field);
                    end
                end else if (hcnt_c == bmp24_pkg::IDX_HEIGHT) begin
                    if (n_field > 32'(MAX_DIM)) begin
                        o_res_valid = 1'b1;
                        o_res.kind  = bmp24_pkg::KIND_SIZE;
                        n_phase     = bmp24_pkg::PH_IDLE;
                    end else begin
                        n_height = DIM_W'(n_field);
                    end
                end else if (hcnt_c == bmp24_pkg::IDX_DEPTH) begin
                    if (n_field[31:16] != bmp24_pkg::DEPTH_BPP) begin
                        o_res_valid = 1'b1;
                        o_res.kind  = bmp24_pkg::KIND_NOT_24;
                        n_phase     = bmp24_pkg::PH_IDLE;
                    end
                end else if (hcnt_c == bmp24_pkg::IDX_HDR_END) begin
                    n_col   = '0;
                    n_row   = '0;
                    n_bip   = 2'd0;
                    n_phase = (r_width != '0 && r_height != '0) ?
                              bmp24_pkg::PH_PIXEL : bmp24_pkg::PH_IDLE;
                end
            end

            bmp24_pkg::PH_PIXEL: begin
                case (r_bip)
                    2'd0: begin
                        n_blue = i_data_byte;
                        n_bip  = 2'd1;
                    end
                    2'd1: begin
                        n_green = i_data_byte;
                        n_bip   = 2'd2;
                    end
                    default: begin
                        n_bip              = 2'd0;
                        o_res_valid        = 1'b1;
                        o_res.kind         = bmp24_pkg::KIND_PIXEL;
                        o_res.red          = i_data_byte;
                        o_res.green        = r_green;
                        o_res.blue         = r_blue;
                        o_res.column       = 12'(r_col);
                        o_res.row          = 12'(r_row);
                        o_res.last_pixel   = (col_inc == r_width) && (row_inc == r_height);
                        o_res.image_width  = 13'(r_width);
                        o_res.image_height = 13'(r_height);
                        if (col_inc >= r_width) begin
                            n_col = '0;
                            n_row = row_inc;
                            if (row_inc >= r_height) begin
                                n_phase = bmp24_pkg::PH_IDLE;
                            end else begin
                                n_pad   = pad_row;
                                n_phase = (pad_row != 2'd0) ?
                                          bmp24_pkg::PH_PAD : bmp24_pkg::PH_PIXEL;
                            end
                        end else begin
                            n_col = col_inc;
                        end
                    end
                endcase
            end

            bmp24_pkg::PH_PAD: begin
                if (r_pad != 2'd0) begin
                    n_pad = r_pad - 2'd1;
                end
                if (n_pad == 2'd0) begin
                    n_phase = bmp24_pkg::PH_PIXEL;
                end
            end

            default: begin
                n_phase = phase_c;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bmp24_pkg::PH_HEADER;
            r_hcnt  <= 6'd0;
            r_bip   <= 2'd0;
            r_pad   <= 2'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_hcnt  <= n_hcnt;
            r_bip   <= n_bip;
            r_pad   <= n_pad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_first  <= n_first;
            r_field  <= n_field;
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
            r_blue   <= n_blue;
            r_green  <= n_green;
        end
    end

    `BMP24_ASSERT_NOW(a_pad_nonzero, i_clk, i_rst_n, r_phase == bmp24_pkg::PH_PAD, r_pad != 2'd0, "padding phase with zero count")
    `BMP24_ASSERT_NOW(a_pixel_byte_range, i_clk, i_rst_n, r_phase == bmp24_pkg::PH_PIXEL, r_bip != 2'd3, "pixel byte index out of range")
    `BMP24_ASSERT_NEXT(a_restart_header, i_clk, i_rst_n, i_step && i_file_start, r_hcnt == 6'd1, "file start did not restart the header count")

endmodule
